/* rtl/core/dtn_pkg.sv */
// ----------------------------------------------------------------------------
// dtn_pkg
// Shared types, constants and tree helper functions for the double binary
// tree neighbour block.
// ----------------------------------------------------------------------------
package dtn_pkg;

  localparam int MAX_RANKS = 1024;

  // register indexes on the configuration port
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_ROOT = 1'b1;

  // internal rank arithmetic, wide enough for -1 and a little headroom
  typedef logic signed [11:0] val_t;
  typedef logic [3:0] hgt_t;

  typedef struct packed {
    logic start;
    val_t n;
    val_t idx;
    val_t top;
  } walk_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic colour;
  } walk_rsp_t;

  // position of the highest set bit
  function automatic hgt_t msb_pos(val_t x);
    hgt_t m;
    m = '0;
    for (int b = 0; b < 12; b++) begin
      if (x[b]) m = hgt_t'(b);
    end
    return m;
  endfunction

  // one less than the largest power of two not above x; -1 below 1
  function automatic val_t tree_top(val_t x);
    hgt_t m;
    m = msb_pos(x);
    if (x < 12'sd1) return -12'sd1;
    return (12'sd1 <<< m) - 12'sd1;
  endfunction

  // height of an in-order position: 0 for leaves (even positions)
  function automatic hgt_t node_height(val_t v);
    hgt_t h;
    val_t w;
    h = '0;
    w = v + 12'sd1;
    if (!v[11] && v[0]) begin
      for (int b = 11; b >= 1; b--) begin
        if (w[b]) h = hgt_t'(b);
      end
    end
    return h;
  endfunction

endpackage

/* rtl/core/dtn_node_nbrs.sv */
// ----------------------------------------------------------------------------
// dtn_node_nbrs
// Parent and children of one position in an in-order binary tree of n nodes.
// ----------------------------------------------------------------------------
module dtn_node_nbrs (
  input  dtn_pkg::val_t n,
  input  dtn_pkg::val_t v,
  input  dtn_pkg::hgt_t h,
  input  dtn_pkg::val_t top,
  output dtn_pkg::val_t ch0,
  output dtn_pkg::val_t ch1,
  output dtn_pkg::val_t par
);

  dtn_pkg::val_t half;
  dtn_pkg::val_t full;
  dtn_pkg::val_t w;
  dtn_pkg::val_t vp;
  dtn_pkg::val_t jump;

  always_comb begin
    half = (h == 4'd0) ? 12'sd0 : (12'sd1 <<< (h - 4'd1));
    full = 12'sd1 <<< h;
    w    = v + half;
    vp   = v + 12'sd1;
    // right link past the end of the tree drops into the largest full subtree
    jump = v + dtn_pkg::tree_top(n - v - 12'sd1) + 12'sd1;

    ch0 = (h == 4'd0) ? -12'sd1 : v - half;

    if (v == n - 12'sd1 || h == 4'd0) begin
      ch1 = -12'sd1;
    end else if (v == top) begin
      ch1 = jump;
    end else begin
      ch1 = (w < n) ? w : jump;
    end

    if (v == top) begin
      par = -12'sd1;
    end else if (h == 4'd0) begin
      par = v[1] ? v - 12'sd1 : v + 12'sd1;
    end else if ((vp & (full <<< 1)) != 12'sd0 || vp + full > n) begin
      par = vp - full - 12'sd1;
    end else begin
      par = vp + full - 12'sd1;
    end
  end

endmodule

/* rtl/core/dtn_colour_walk.sv */
// ----------------------------------------------------------------------------
// dtn_colour_walk
// Iterative link colouring: walks up the first tree one level per cycle,
// folding the direction of each step into a parity.
// ----------------------------------------------------------------------------
module dtn_colour_walk (
  input  logic                clk,
  input  logic                rst,
  input  dtn_pkg::walk_req_t  req,
  output dtn_pkg::walk_rsp_t  rsp
);

  logic         busy;
  logic         done;
  logic         colour;
  logic [11:0]  i;
  dtn_pkg::hgt_t h;
  logic         acc;
  logic         flip;
  logic [11:0]  n;
  logic [11:0]  top;

  logic [11:0]  masked;
  dtn_pkg::hgt_t p;
  logic [11:0]  pw;
  logic [12:0]  sum;
  logic         hi;
  logic         up;
  logic         stop;
  logic [11:0]  i_next;

  always_comb begin
    masked = i & ~((12'd1 << h) - 12'd1);
    p = '0;
    for (int b = 11; b >= 0; b--) begin
      if (masked[b]) p = dtn_pkg::hgt_t'(b);
    end
    pw     = 12'd1 << p;
    sum    = {1'b0, i} + {1'b0, pw};
    hi     = (({1'b0, i} & ({1'b0, pw} << 1)) != 13'd0);
    up     = !hi && !(sum > {1'b0, n});
    i_next = up ? sum[11:0] : i - pw;
    stop   = (i == top) || (i == 12'd0) || (masked == 12'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (stop) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          colour <= ~acc;
        end else begin
          i   <= i_next;
          h   <= p;
          acc <= acc ^ flip ^ up;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        i    <= req.idx;
        h    <= 4'd1;
        acc  <= 1'b0;
        flip <= req.n[1];
        n    <= req.n;
        top  <= req.top;
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.colour = colour;

endmodule

/* rtl/core/double_binary_tree_neighbors.sv */
// ----------------------------------------------------------------------------
// double_binary_tree_neighbors
// Neighbours of one rank in a coloured double binary tree (tree + mirror).
// Sequence: out-of-range or root items skip the neighbour and colour-walk
//   states; others run up to three colour walks, one after another.
// Throughput: one item at a time; the next is taken once the result is
//   written to the output register.
// Reset: synchronous; cfg_size returns to 3, cfg_root to 0, no result held.
// ----------------------------------------------------------------------------
module double_binary_tree_neighbors (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         node_rank,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] parent_a,
  output logic signed [10:0] parent_b,
  output logic signed [10:0] child_a,
  output logic signed [10:0] child_b,
  output logic               parent_a_tree,
  output logic               parent_b_tree,
  output logic               child_a_tree,
  output logic               child_b_tree,
  output logic [3:0]         depth_a,
  output logic [3:0]         depth_b,
  output logic               is_root_node,
  output logic               invalid
);

  // sequencer
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an item
  localparam logic [2:0] S_PREP   = 3'd1;  // renumbering, tree roots, heights
  localparam logic [2:0] S_NBRS   = 3'd2;  // neighbours in both trees
  localparam logic [2:0] S_WSTART = 3'd3;  // launch one colour walk
  localparam logic [2:0] S_WWAIT  = 3'd4;  // wait for the walk to finish
  localparam logic [2:0] S_FIN    = 3'd5;  // assemble result, load output

  logic [2:0] state;

  logic [10:0] cfg_size;
  logic [9:0]  cfg_root;
  logic [9:0]  rank_q;

  // per-item working registers
  logic          bad;
  logic          is_root;
  logic          extra_on;
  logic          spare;
  dtn_pkg::val_t vrank;
  dtn_pkg::val_t vr2;
  dtn_pkg::val_t vsize;
  dtn_pkg::val_t t1_root;
  dtn_pkg::val_t t2_root;
  dtn_pkg::hgt_t max_h;
  dtn_pkg::hgt_t h1;
  dtn_pkg::hgt_t h2;
  dtn_pkg::val_t ch1_0, ch1_1, par1;
  dtn_pkg::val_t mc0, mc1, par2;
  logic [1:0]    job;
  logic [2:0]    col;

  // ---- set-up: renumber the non-root ranks, find tree roots and heights ----
  dtn_pkg::val_t size_v, root_v, rank_v;
  dtn_pkg::val_t vr0_c, vs0_c, vs_c, vr_c, vr2_c, t1_c;
  logic          bad_c, eon_c, sp_c;
  dtn_pkg::hgt_t mh_c;

  always_comb begin
    size_v = dtn_pkg::val_t'({1'b0, cfg_size});
    root_v = dtn_pkg::val_t'({2'b0, cfg_root});
    rank_v = dtn_pkg::val_t'({2'b0, rank_q});
    bad_c  = size_v < 12'sd3 || size_v > dtn_pkg::val_t'(dtn_pkg::MAX_RANKS) ||
             rank_v >= size_v || root_v >= size_v;
    vr0_c  = (rank_v < root_v) ? rank_v : rank_v - 12'sd1;
    vs0_c  = size_v - 12'sd1;
    // odd non-root count: the last one is the spare node
    eon_c  = vs0_c[0];
    vs_c   = eon_c ? vs0_c - 12'sd1 : vs0_c;
    sp_c   = eon_c && (vr0_c == vs_c);
    vr_c   = sp_c ? 12'sd0 : vr0_c;
    mh_c   = dtn_pkg::msb_pos(vs_c);
    t1_c   = (12'sd1 <<< mh_c) - 12'sd1;
    vr2_c  = vs_c - 12'sd1 - vr_c;
  end

  // ---- tree neighbours: first tree and mirror position ----
  dtn_pkg::val_t na_ch0, na_ch1, na_par;
  dtn_pkg::val_t nb_ch0, nb_ch1, nb_par;

  dtn_node_nbrs u_nbrs_first (
    .n   (vsize),
    .v   (vrank),
    .h   (h1),
    .top (t1_root),
    .ch0 (na_ch0),
    .ch1 (na_ch1),
    .par (na_par)
  );

  dtn_node_nbrs u_nbrs_mirror (
    .n   (vsize),
    .v   (vr2),
    .h   (h2),
    .top (t1_root),
    .ch0 (nb_ch0),
    .ch1 (nb_ch1),
    .par (nb_par)
  );

  // ---- colour walks: the node itself, then its two children ----
  // A leaf of the first tree is an inner node of the mirror, so the walks run
  // on whichever of the two positions is inner.
  dtn_pkg::walk_req_t walk_req;
  dtn_pkg::walk_rsp_t walk_rsp;
  dtn_pkg::hgt_t      hsel;
  dtn_pkg::val_t      vsel, chs, arg;
  logic               arg_ok;

  always_comb begin
    hsel = (h1 != 4'd0) ? h1 : h2;
    vsel = (h1 != 4'd0) ? vrank : vr2;
    if (job == 2'd1) begin
      chs = (h1 != 4'd0) ? ch1_0 : mc0;
    end else begin
      chs = (h1 != 4'd0) ? ch1_1 : mc1;
    end
    if (job == 2'd0) begin
      arg    = vsel + 12'sd1;
      arg_ok = 1'b1;
    end else begin
      // children that are leaves are coloured through their mirror position
      arg    = ((hsel > 4'd1) ? chs : vsize - 12'sd1 - chs) + 12'sd1;
      arg_ok = !chs[11];
    end
    walk_req.start = (state == S_WSTART) && arg_ok;
    walk_req.n     = vsize;
    walk_req.idx   = arg;
    walk_req.top   = t1_root + 12'sd1;
  end

  dtn_colour_walk u_walk (
    .clk (clk),
    .rst (rst),
    .req (walk_req),
    .rsp (walk_rsp)
  );

  // ---- result assembly ----
  function automatic dtn_pkg::val_t to_orig(dtn_pkg::val_t v, dtn_pkg::val_t r);
    dtn_pkg::val_t o;
    if (v[11]) o = -12'sd1;
    else if (v < r) o = v;
    else o = v + 12'sd1;
    return o;
  endfunction

  dtn_pkg::val_t p_f [2];
  dtn_pkg::val_t c_f [2];
  logic [1:0]    pt_f, ct_f;
  logic [3:0]    hd0_f, hd1_f;
  dtn_pkg::val_t t2p_f, t2c0_f, t2c1_f, c1ch0_f, c1ch1_f;
  logic          c1p_f, c2p_f, c1c0_f, c1c1_f, c2c0_f, c2c1_f, p1r_f, p2r_f;

  always_comb begin
    p_f[0] = -12'sd1;
    p_f[1] = -12'sd1;
    c_f[0] = -12'sd1;
    c_f[1] = -12'sd1;
    pt_f   = 2'b00;
    ct_f   = 2'b00;
    hd0_f  = 4'd0;
    hd1_f  = 4'd0;

    t2p_f   = par2[11] ? -12'sd1 : vsize - 12'sd1 - par2;
    t2c0_f  = mc1[11] ? -12'sd1 : vsize - 12'sd1 - mc1;
    t2c1_f  = mc0[11] ? -12'sd1 : vsize - 12'sd1 - mc0;
    c1ch0_f = ch1_0;
    c1ch1_f = ch1_1;

    c1p_f = col[0];
    c2p_f = ~col[0];
    if (h1 != 4'd0) begin
      c1c0_f = col[1];
      c1c1_f = col[2];
      c2c0_f = 1'b0;
      c2c1_f = 1'b0;
    end else begin
      c1c0_f = 1'b0;
      c1c1_f = 1'b0;
      c2c0_f = ~col[2];
      c2c1_f = ~col[1];
    end

    // spare node hangs below mirror node 0 and below the last first-tree node
    if (extra_on) begin
      if (vrank == 12'sd0) begin
        t2c0_f = vsize;
        c2c0_f = ~c2c1_f;
      end
      if (vrank == vsize - 12'sd1) begin
        c1ch1_f = vsize;
        c1c1_f  = ~c1c0_f;
      end
    end

    p1r_f = (vrank == t1_root);
    p2r_f = (vrank == t2_root);
    if (p1r_f || p2r_f) begin
      c1p_f = 1'b1;
      c2p_f = 1'b0;
    end

    if (bad) begin
      // all links absent
    end else if (is_root) begin
      c_f[0] = to_orig(t2_root, dtn_pkg::val_t'({2'b0, cfg_root}));
      c_f[1] = to_orig(t1_root, dtn_pkg::val_t'({2'b0, cfg_root}));
      ct_f   = 2'b01;
    end else begin
      if (p1r_f || !par1[11]) begin
        p_f[c1p_f]  = p1r_f ? dtn_pkg::val_t'({2'b0, cfg_root})
                            : to_orig(par1, dtn_pkg::val_t'({2'b0, cfg_root}));
        pt_f[c1p_f] = 1'b0;
      end
      if (p2r_f || !t2p_f[11]) begin
        p_f[c2p_f]  = p2r_f ? dtn_pkg::val_t'({2'b0, cfg_root})
                            : to_orig(t2p_f, dtn_pkg::val_t'({2'b0, cfg_root}));
        pt_f[c2p_f] = 1'b1;
      end
      if (!c1ch0_f[11]) begin
        c_f[c1c0_f]  = to_orig(c1ch0_f, dtn_pkg::val_t'({2'b0, cfg_root}));
        ct_f[c1c0_f] = 1'b0;
      end
      if (!c1ch1_f[11]) begin
        c_f[c1c1_f]  = to_orig(c1ch1_f, dtn_pkg::val_t'({2'b0, cfg_root}));
        ct_f[c1c1_f] = 1'b0;
      end
      if (!t2c0_f[11]) begin
        c_f[c2c0_f]  = to_orig(t2c0_f, dtn_pkg::val_t'({2'b0, cfg_root}));
        ct_f[c2c0_f] = 1'b1;
      end
      if (!t2c1_f[11]) begin
        c_f[c2c1_f]  = to_orig(t2c1_f, dtn_pkg::val_t'({2'b0, cfg_root}));
        ct_f[c2c1_f] = 1'b1;
      end

      if (spare) begin
        c_f[0]       = -12'sd1;
        c_f[1]       = -12'sd1;
        p_f[~c2c0_f] = to_orig(vsize - 12'sd1, dtn_pkg::val_t'({2'b0, cfg_root}));
        pt_f[~c2c0_f] = 1'b0;
        p_f[c2c0_f]  = to_orig(12'sd0, dtn_pkg::val_t'({2'b0, cfg_root}));
        pt_f[c2c0_f] = 1'b1;
        hd0_f        = max_h + 4'd1;
        hd1_f        = max_h + 4'd1;
      end else begin
        hd0_f = max_h - h1 + 4'd1;
        hd1_f = max_h - h2 + 4'd1;
      end
    end

    // no tree mark on an absent link
    for (int k = 0; k < 2; k++) begin
      if (c_f[k] == -12'sd1) ct_f[k] = 1'b0;
      if (p_f[k] == -12'sd1) pt_f[k] = 1'b0;
    end
  end

  logic out_load;
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);
  assign in_stall = (state != S_IDLE);

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_size  <= 11'd3;
      cfg_root  <= 10'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dtn_pkg::REG_SIZE: cfg_size <= cfg_data;
          dtn_pkg::REG_ROOT: cfg_root <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rank_q <= node_rank;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          bad      <= bad_c;
          is_root  <= (rank_q == cfg_root);
          extra_on <= eon_c;
          spare    <= sp_c;
          vrank    <= vr_c;
          vr2      <= vr2_c;
          vsize    <= vs_c;
          max_h    <= mh_c;
          t1_root  <= t1_c;
          t2_root  <= vs_c - 12'sd1 - t1_c;
          h1       <= dtn_pkg::node_height(vr_c);
          h2       <= dtn_pkg::node_height(vr2_c);
          state    <= (bad_c || rank_q == cfg_root) ? S_FIN : S_NBRS;
        end
        S_NBRS: begin
          ch1_0 <= na_ch0;
          ch1_1 <= na_ch1;
          par1  <= na_par;
          mc0   <= nb_ch0;
          mc1   <= nb_ch1;
          par2  <= nb_par;
          job   <= 2'd0;
          state <= S_WSTART;
        end
        S_WSTART: begin
          if (arg_ok) begin
            state <= S_WWAIT;
          end else begin
            col[job] <= 1'b0;
            job      <= job + 2'd1;
            state    <= (job == 2'd2) ? S_FIN : S_WSTART;
          end
        end
        S_WWAIT: begin
          if (walk_rsp.done) begin
            col[job] <= walk_rsp.colour;
            job      <= job + 2'd1;
            state    <= (job == 2'd2) ? S_FIN : S_WSTART;
          end
        end
        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      parent_a      <= p_f[0][10:0];
      parent_b      <= p_f[1][10:0];
      child_a       <= c_f[0][10:0];
      child_b       <= c_f[1][10:0];
      parent_a_tree <= pt_f[0];
      parent_b_tree <= pt_f[1];
      child_a_tree  <= ct_f[0];
      child_b_tree  <= ct_f[1];
      depth_a       <= hd0_f;
      depth_b       <= hd1_f;
      is_root_node  <= !bad && is_root;
      invalid       <= bad;
    end
  end

  // ---- checks ----
  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> parent_a == 11'h7FF && child_a == 11'h7FF &&
                             parent_b == 11'h7FF && !is_root_node)
    else $error("out-of-range item carries links");

  a_root_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_root_node |-> depth_a == 4'd0 && depth_b == 4'd0 &&
                                  parent_a == 11'h7FF && parent_b == 11'h7FF)
    else $error("root item has a parent or non-zero depth");

  a_walk_owned: assert property (@(posedge clk) disable iff (rst)
    walk_rsp.busy |-> state == S_WWAIT)
    else $error("colour walk running outside its wait state");

endmodule
